[rtl/core/brs_pkg.sv]
// Shared types and default sizes for the Brent-Dekker root step block.
// No dependencies; imported by brs_alu and brent_root_step.
package brs_pkg;

  localparam int VALUE_WIDTH_D   = 48;
  localparam int FRACTION_BITS_D = 32;
  // multiplier bits consumed per cycle by the shared multiply
  localparam int MUL_CHUNK       = 16;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

endpackage

[rtl/core/brs_alu.sv]
// Shared saturating fixed-point unit: add, subtract, chunked multiply, restoring divide.
// Depends on brs_pkg.
module brs_alu import brs_pkg::*; #(
  parameter int W = VALUE_WIDTH_D,
  parameter int F = FRACTION_BITS_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alu_req_t            req,
  input  logic signed [W-1:0] op_x,
  input  logic signed [W-1:0] op_y,
  output alu_rsp_t            rsp,
  output logic signed [W-1:0] res
);

  localparam int NCH = (W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MYW = NCH * MUL_CHUNK;
  localparam int PW  = W + MYW;
  localparam int VW  = PW + 1;
  localparam int NW  = W + F;
  localparam int CW  = $clog2(NW + 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MRND, S_DIV, S_DRND, S_FIN} st_t;

  st_t                st_r;
  logic               done_r, sat_r, neg_r;
  logic signed [W-1:0] res_r;
  logic [VW-1:0]      val_r;
  logic [W-1:0]       mx_r;
  logic [MYW-1:0]     my_r;
  logic [NW-1:0]      num_r, q_r;
  logic [W:0]         rem_r;
  logic [CW-1:0]      cnt_r;

  logic [W-1:0]              mag_x, mag_y;
  logic signed [W:0]         sum;
  logic                      sum_ovf;
  logic                      done_nxt;
  logic [W+MUL_CHUNK-1:0]    pp;
  logic [W:0]                rsh, twice;
  logic                      fits;
  logic [VW-1:0]             limv, rnd;
  logic [W-1:0]              mg;
  logic signed [W-1:0]       vmax, vmin;

  // operand magnitudes and the saturating add / subtract
  always_comb begin
    vmax    = {1'b0, {(W-1){1'b1}}};
    vmin    = {1'b1, {(W-1){1'b0}}};
    mag_x   = op_x[W-1] ? W'(-op_x) : W'(op_x);
    mag_y   = op_y[W-1] ? W'(-op_y) : W'(op_y);
    sum     = (req.op == ALU_SUB) ? ({op_x[W-1], op_x} - {op_y[W-1], op_y})
                                  : ({op_x[W-1], op_x} + {op_y[W-1], op_y});
    sum_ovf = sum[W] != sum[W-1];
    // pulse done: add, subtract and divide by zero at once, the rest after S_FIN
    done_nxt = (st_r == S_FIN) ||
               (st_r == S_IDLE && req.start && (req.op != ALU_MUL) &&
                (req.op != ALU_DIV || op_y == '0));
  end

  // one multiply chunk, one divide bit, rounding and clamp
  always_comb begin
    pp    = {{MUL_CHUNK{1'b0}}, mx_r} * {{W{1'b0}}, my_r[MYW-1 -: MUL_CHUNK]};
    rsh   = {rem_r[W-1:0], num_r[NW-1]};
    fits  = rsh >= {1'b0, mx_r};
    twice = {rem_r[W-1:0], 1'b0};
    rnd   = val_r + (VW'(1) << (F - 1));
    limv  = (VW'(1) << (W - 1)) - VW'(1) + VW'(neg_r);
    mg    = (val_r > limv) ? limv[W-1:0] : val_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= done_nxt;
      case (st_r)
        S_IDLE: begin
          if (req.start) begin
            neg_r <= op_x[W-1] ^ op_y[W-1];
            mx_r  <= (req.op == ALU_DIV) ? mag_y : mag_x;
            case (req.op)
              ALU_ADD, ALU_SUB: begin
                res_r  <= sum_ovf ? (sum[W] ? vmin : vmax) : sum[W-1:0];
                sat_r  <= sum_ovf;
              end
              ALU_MUL: begin
                my_r  <= MYW'(mag_y);
                val_r <= '0;
                cnt_r <= CW'(NCH - 1);
                st_r  <= S_MUL;
              end
              default: begin
                if (op_y == '0) begin
                  // divide by zero: zero over zero gives zero, else the signed limit
                  res_r  <= (op_x == '0) ? '0 : (op_x[W-1] ? vmin : vmax);
                  sat_r  <= 1'b1;
                end else begin
                  num_r <= {mag_x, {F{1'b0}}};
                  rem_r <= '0;
                  q_r   <= '0;
                  cnt_r <= CW'(NW - 1);
                  st_r  <= S_DIV;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          val_r <= (val_r << MUL_CHUNK) + VW'(pp);
          my_r  <= my_r << MUL_CHUNK;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) st_r <= S_MRND;
        end
        S_MRND: begin
          val_r <= rnd >> F;
          st_r  <= S_FIN;
        end
        S_DIV: begin
          rem_r <= fits ? (rsh - {1'b0, mx_r}) : rsh;
          q_r   <= {q_r[NW-2:0], fits};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) st_r <= S_DRND;
        end
        S_DRND: begin
          // round half away from zero on the remainder
          val_r <= VW'(q_r) + VW'(twice >= {1'b0, mx_r});
          st_r  <= S_FIN;
        end
        S_FIN: begin
          res_r  <= neg_r ? W'(-mg) : mg;
          sat_r  <= val_r > limv;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign res      = res_r;

endmodule

[rtl/core/brent_root_step.sv]
// Brent-Dekker root step: bracket state, step sequencer and output word register.
// Depends on brs_pkg and brs_alu.
//
// Usage: write left_end (index 0) and right_end (index 1) on the cfg port while
// idle. Send a start word (kind 0) carrying f at both ends; each result word gives
// the next query point. Evaluate f there and send it back as a kind 1 word.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// One word is taken at a time; in_stall stays high from acceptance until the
// result has been loaded into the output register.
// An interpolation step runs six divides and six multiplies on the shared
// arithmetic unit; a secant step one divide, one multiply and three subtracts;
// a step that finds a root, or one that holds it, does not use the unit.
// Reset (synchronous, rst_n low) clears the bracket state and the output valid,
// and restores right_end to 1.0. When out_stall is high the result word holds
// and the block waits before loading the next one.
module brent_root_step import brs_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_D,
  parameter int FRACTION_BITS = FRACTION_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic        [VALUE_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic signed [VALUE_WIDTH-1:0] in_value_one,
  input  logic signed [VALUE_WIDTH-1:0] in_value_two,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_query_point,
  output logic signed [VALUE_WIDTH-1:0] out_best_estimate,
  output logic signed [VALUE_WIDTH-1:0] out_value_at_best,
  output logic        [VALUE_WIDTH-2:0] out_bracket_width,
  output logic                          out_root_found,
  output logic                          out_saturated
);

  localparam int W = VALUE_WIDTH;
  localparam logic CFG_LEFT   = 1'b0;
  localparam logic CFG_RIGHT  = 1'b1;
  localparam logic KIND_START = 1'b0;
  localparam logic [4:0] PC_IQI = 5'd0;
  localparam logic [4:0] PC_SEC = 5'd20;

  typedef enum logic [2:0] {ST_IDLE, ST_ORDER, ST_PICK, ST_ISSUE, ST_WAIT, ST_CHECK,
                            ST_FINISH} state_t;
  typedef enum logic [3:0] {SRC_A, SRC_B, SRC_C, SRC_FA, SRC_FB, SRC_FC,
                            SRC_T0, SRC_T1, SRC_T2} src_t;
  typedef enum logic [1:0] {DST_T0, DST_T1, DST_T2} dst_t;
  typedef struct packed {
    alu_op_t op;
    src_t    sx;
    src_t    sy;
    dst_t    dst;
    logic    last;
  } uc_t;

  // step program: interpolation terms from PC_IQI, secant from PC_SEC
  function automatic uc_t ucode(input logic [4:0] pc);
    uc_t u;
    u = '{ALU_SUB, SRC_B, SRC_T0, DST_T0, 1'b1};
    case (pc)
      5'd0:  u = '{ALU_SUB, SRC_FA, SRC_FB, DST_T0, 1'b0};
      5'd1:  u = '{ALU_DIV, SRC_FB, SRC_T0, DST_T0, 1'b0};
      5'd2:  u = '{ALU_MUL, SRC_A,  SRC_T0, DST_T0, 1'b0};
      5'd3:  u = '{ALU_SUB, SRC_FA, SRC_FC, DST_T1, 1'b0};
      5'd4:  u = '{ALU_DIV, SRC_FC, SRC_T1, DST_T1, 1'b0};
      5'd5:  u = '{ALU_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0};
      5'd6:  u = '{ALU_SUB, SRC_FB, SRC_FA, DST_T1, 1'b0};
      5'd7:  u = '{ALU_DIV, SRC_FA, SRC_T1, DST_T1, 1'b0};
      5'd8:  u = '{ALU_MUL, SRC_B,  SRC_T1, DST_T1, 1'b0};
      5'd9:  u = '{ALU_SUB, SRC_FB, SRC_FC, DST_T2, 1'b0};
      5'd10: u = '{ALU_DIV, SRC_FC, SRC_T2, DST_T2, 1'b0};
      5'd11: u = '{ALU_MUL, SRC_T1, SRC_T2, DST_T1, 1'b0};
      5'd12: u = '{ALU_ADD, SRC_T0, SRC_T1, DST_T0, 1'b0};
      5'd13: u = '{ALU_SUB, SRC_FC, SRC_FA, DST_T1, 1'b0};
      5'd14: u = '{ALU_DIV, SRC_FA, SRC_T1, DST_T1, 1'b0};
      5'd15: u = '{ALU_MUL, SRC_C,  SRC_T1, DST_T1, 1'b0};
      5'd16: u = '{ALU_SUB, SRC_FC, SRC_FB, DST_T2, 1'b0};
      5'd17: u = '{ALU_DIV, SRC_FB, SRC_T2, DST_T2, 1'b0};
      5'd18: u = '{ALU_MUL, SRC_T1, SRC_T2, DST_T1, 1'b0};
      5'd19: u = '{ALU_ADD, SRC_T0, SRC_T1, DST_T0, 1'b1};
      5'd20: u = '{ALU_SUB, SRC_B,  SRC_A,  DST_T0, 1'b0};
      5'd21: u = '{ALU_SUB, SRC_FB, SRC_FA, DST_T1, 1'b0};
      5'd22: u = '{ALU_DIV, SRC_FB, SRC_T1, DST_T1, 1'b0};
      5'd23: u = '{ALU_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0};
      default: u = '{ALU_SUB, SRC_B, SRC_T0, DST_T0, 1'b1};
    endcase
    return u;
  endfunction

  state_t state_r;
  logic signed [W-1:0] left_r, right_r;
  logic signed [W-1:0] a_r, b_r, c_r, d_r, fa_r, fb_r, fc_r, pend_r;
  logic signed [W-1:0] t0_r, t1_r, t2_r;
  logic bis_r, start_r, held_r, sat_r;
  logic [4:0] pc_r;
  logic out_valid_r, root_r, osat_r;
  logic signed [W-1:0] oq_r, ob_r, ofb_r;
  logic [W-2:0] ow_r;

  uc_t uc;
  alu_req_t req;
  alu_rsp_t rsp;
  logic signed [W-1:0] op_x, op_y, alu_res;

  logic [W-1:0] mag_fa, mag_fb;
  logic swap, opposite;
  logic signed [W-1:0] na, nb, nfa, nfb;
  logic signed [W+1:0] q_sum;
  logic signed [W-1:0] quarter, lo, hi, mid;
  logic signed [W:0] mid_sum, s_b, b_c, c_d, wdiff;
  logic [W:0] ds, dr, half, wabs;
  logic reject, out_free, wover;

  function automatic logic signed [W-1:0] pick(input src_t s, input logic signed [W-1:0] a,
      input logic signed [W-1:0] b, input logic signed [W-1:0] c,
      input logic signed [W-1:0] fa, input logic signed [W-1:0] fb,
      input logic signed [W-1:0] fc, input logic signed [W-1:0] t0,
      input logic signed [W-1:0] t1, input logic signed [W-1:0] t2);
    logic signed [W-1:0] v;
    case (s)
      SRC_A:   v = a;
      SRC_B:   v = b;
      SRC_C:   v = c;
      SRC_FA:  v = fa;
      SRC_FB:  v = fb;
      SRC_FC:  v = fc;
      SRC_T0:  v = t0;
      SRC_T1:  v = t1;
      default: v = t2;
    endcase
    return v;
  endfunction

  // operand selection for the shared unit
  always_comb begin
    uc        = ucode(pc_r);
    req.start = state_r == ST_ISSUE;
    req.op    = uc.op;
    op_x      = pick(uc.sx, a_r, b_r, c_r, fa_r, fb_r, fc_r, t0_r, t1_r, t2_r);
    op_y      = pick(uc.sy, a_r, b_r, c_r, fa_r, fb_r, fc_r, t0_r, t1_r, t2_r);
  end

  brs_alu #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .op_x (op_x),
    .op_y (op_y),
    .rsp  (rsp),
    .res  (alu_res)
  );

  // keep the end with the smaller residual as best
  always_comb begin
    mag_fa   = fa_r[W-1] ? W'(-fa_r) : W'(fa_r);
    mag_fb   = fb_r[W-1] ? W'(-fb_r) : W'(fb_r);
    swap     = mag_fa < mag_fb;
    na       = swap ? b_r : a_r;
    nb       = swap ? a_r : b_r;
    nfa      = swap ? fb_r : fa_r;
    nfb      = swap ? fa_r : fb_r;
    opposite = (fa_r < 0 && in_value_one > 0) || (fa_r > 0 && in_value_one < 0);
  end

  // candidate acceptance: quarter-point window and step-size test
  always_comb begin
    q_sum   = ({{2{a_r[W-1]}}, a_r} <<< 1) + {{2{a_r[W-1]}}, a_r} + {{2{b_r[W-1]}}, b_r};
    quarter = W'(q_sum >>> 2);
    lo      = (quarter < b_r) ? quarter : b_r;
    hi      = (quarter < b_r) ? b_r : quarter;
    mid_sum = {a_r[W-1], a_r} + {b_r[W-1], b_r};
    mid     = W'(mid_sum >>> 1);
    s_b     = {t0_r[W-1], t0_r} - {b_r[W-1], b_r};
    b_c     = {b_r[W-1], b_r} - {c_r[W-1], c_r};
    c_d     = {c_r[W-1], c_r} - {d_r[W-1], d_r};
    ds      = s_b[W] ? (W+1)'(-s_b) : (W+1)'(s_b);
    dr      = bis_r ? (b_c[W] ? (W+1)'(-b_c) : (W+1)'(b_c))
                    : (c_d[W] ? (W+1)'(-c_d) : (W+1)'(c_d));
    half    = (dr >> 1) + (W+1)'(dr[0]);
    reject  = (t0_r < lo) || (t0_r > hi) || (ds >= half);
  end

  // bracket width with clamp
  always_comb begin
    wdiff    = {b_r[W-1], b_r} - {a_r[W-1], a_r};
    wabs     = wdiff[W] ? (W+1)'(-wdiff) : (W+1)'(wdiff);
    wover    = wabs > {2'b00, {(W-1){1'b1}}};
    out_free = !out_valid_r || !out_stall;
  end

  assign in_stall = state_r != ST_IDLE;

  // sequencer, bracket state and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      right_r     <= W'(1) << FRACTION_BITS;
      a_r  <= '0; b_r  <= '0; c_r  <= '0; d_r <= '0;
      fa_r <= '0; fb_r <= '0; fc_r <= '0;
      pend_r <= '0;
      bis_r  <= 1'b1;
      start_r <= 1'b0;
      held_r  <= 1'b0;
      sat_r   <= 1'b0;
      pc_r    <= PC_IQI;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEFT:  left_r  <= cfg_data;
          CFG_RIGHT: right_r <= cfg_data;
          default:   ;
        endcase
      end
      // drop the word once taken, unless a new one is loaded this cycle
      if (out_valid_r && !out_stall && state_r != ST_FINISH) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sat_r  <= 1'b0;
            held_r <= 1'b0;
            if (in_kind == KIND_START) begin
              a_r     <= left_r;
              b_r     <= right_r;
              fa_r    <= in_value_one;
              fb_r    <= in_value_two;
              start_r <= 1'b1;
              state_r <= ST_ORDER;
            end else if (fb_r == '0) begin
              // root already found: hold all state
              held_r  <= 1'b1;
              pend_r  <= b_r;
              state_r <= ST_FINISH;
            end else begin
              d_r  <= c_r;
              c_r  <= b_r;
              fc_r <= fb_r;
              if (opposite) begin
                b_r  <= pend_r;
                fb_r <= in_value_one;
              end else begin
                a_r  <= pend_r;
                fa_r <= in_value_one;
              end
              start_r <= 1'b0;
              state_r <= ST_ORDER;
            end
          end
        end
        ST_ORDER: begin
          a_r  <= na;
          b_r  <= nb;
          fa_r <= nfa;
          fb_r <= nfb;
          if (start_r) begin
            c_r   <= na;
            d_r   <= na;
            fc_r  <= nfa;
            bis_r <= 1'b1;
          end
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          if (fb_r == '0) begin
            pend_r  <= b_r;
            state_r <= ST_FINISH;
          end else begin
            pc_r    <= (fa_r != fc_r && fb_r != fc_r) ? PC_IQI : PC_SEC;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (rsp.done) begin
            sat_r <= sat_r | rsp.sat;
            case (uc.dst)
              DST_T0:  t0_r <= alu_res;
              DST_T1:  t1_r <= alu_res;
              default: t2_r <= alu_res;
            endcase
            if (uc.last) begin
              state_r <= ST_CHECK;
            end else begin
              pc_r    <= pc_r + 5'd1;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_CHECK: begin
          pend_r  <= reject ? mid : t0_r;
          bis_r   <= reject;
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            oq_r   <= pend_r;
            ob_r   <= b_r;
            ofb_r  <= fb_r;
            root_r <= fb_r == '0;
            if (held_r) begin
              ow_r   <= '0;
              osat_r <= sat_r;
            end else begin
              ow_r   <= wover ? {(W-1){1'b1}} : wabs[W-2:0];
              osat_r <= sat_r | wover;
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_query_point   = oq_r;
  assign out_best_estimate = ob_r;
  assign out_value_at_best = ofb_r;
  assign out_bracket_width = ow_r;
  assign out_root_found    = root_r;
  assign out_saturated     = osat_r;

endmodule
